// ===== src/flet_pkg.sv =====
// ============================================================================
// flet_pkg
// Shared constants, codes and control structures of the first/last extremum
// tracker.
// ============================================================================
`default_nettype none

package flet_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int INDEX_BITS_DEF = 48;
  localparam int FRAC_BITS      = 24;
  localparam int RATIO_BITS     = 64;
  localparam int TOL_BITS       = 16;
  localparam int MODE_BITS      = 2;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1) << FRAC_BITS;
  localparam logic [RATIO_BITS-1:0] RATIO_SAT = {1'b0, {(RATIO_BITS-1){1'b1}}};

  localparam logic [MODE_BITS-1:0] MODE_VAL_MIN = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_VAL_MAX = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_RAT_MIN = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_RAT_MAX = 2'd3;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_TRACK_MODE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RATIO_TOL  = 2'd1;

  // Operand selection for a ratio computation.
  localparam logic [1:0] RSEL_SAMPLE = 2'd0;
  localparam logic [1:0] RSEL_LAST   = 2'd1;
  localparam logic [1:0] RSEL_FIRST  = 2'd2;

  // How the take flags are evaluated.
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_VALUE  = 3'd1;
  localparam logic [2:0] EV_FILL   = 3'd2;
  localparam logic [2:0] EV_RLAST  = 3'd3;
  localparam logic [2:0] EV_RFIRST = 3'd4;

  typedef struct packed {
    logic       load;
    logic       calc_sum;
    logic [2:0] eval;
    logic [1:0] rsel;
    logic       rstore;
    logic       div_start;
    logic       div_store;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic mode_ratio;
    logic last_empty;
    logic take_last;
    logic special;
    logic div_busy;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

// ===== src/flet_div.sv =====
// ============================================================================
// flet_div
// Restoring divider, one quotient bit per cycle, computing
// floor(numer * 2^FRAC_BITS / denom) on unsigned magnitudes.
// ============================================================================
`default_nettype none

module flet_div #(
  parameter int VALUE_BITS = flet_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     start,
  input  wire logic [VALUE_BITS-1:0]                    numer,
  input  wire logic [VALUE_BITS-1:0]                    denom,
  output logic                                          busy,
  output logic                                          done,
  output logic [VALUE_BITS+flet_pkg::FRAC_BITS-1:0]     quot
);

  localparam int DW = VALUE_BITS + flet_pkg::FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DW-1:0]     acc_r, acc_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] den_r;
  logic [VALUE_BITS:0]   rem_sh;
  logic                  ge;

  assign rem_sh = {rem_r, acc_r[DW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      acc_nxt  = {numer, {flet_pkg::FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? VALUE_BITS'(rem_sh - {1'b0, den_r}) : VALUE_BITS'(rem_sh);
      acc_nxt = {acc_r[DW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= denom;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = acc_r;

endmodule

`default_nettype wire

// ===== src/flet_datapath.sv =====
// ============================================================================
// flet_datapath
// Configuration registers, sample holding registers, saturating sum, value
// and ratio comparisons, and the first and last extremum records.
// ============================================================================
`default_nettype none

module flet_datapath #(
  parameter int VALUE_BITS = flet_pkg::VALUE_BITS_DEF,
  parameter int INDEX_BITS = flet_pkg::INDEX_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [flet_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [flet_pkg::TOL_BITS-1:0]        cfg_data,
  input  wire logic [VALUE_BITS-1:0]                in_value,
  input  wire logic [VALUE_BITS-1:0]                in_base,
  input  wire logic [INDEX_BITS-1:0]                in_index,
  input  wire logic [INDEX_BITS-1:0]                in_delta,
  input  wire logic [VALUE_BITS-1:0]                in_factor,
  input  wire logic [VALUE_BITS-1:0]                in_meas,
  input  wire flet_pkg::cmd_t                       cmd,
  output flet_pkg::status_t                         sts,
  output logic [2*(4*VALUE_BITS+2*INDEX_BITS)-1:0]  rec_bus
);

  localparam int VB = VALUE_BITS;
  localparam int RB = flet_pkg::RATIO_BITS;
  localparam int DW = VALUE_BITS + flet_pkg::FRAC_BITS;
  localparam int QX = (DW > RB) ? DW : RB;

  localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

  logic [flet_pkg::MODE_BITS-1:0] mode_r;
  logic [flet_pkg::TOL_BITS-1:0]  tol_r;

  logic signed [VB-1:0] s_value_r, s_base_r, s_factor_r, s_meas_r, s_sum_r;
  logic [INDEX_BITS-1:0] s_index_r, s_delta_r;

  logic signed [VB-1:0] first_sum_r, first_base_r, first_factor_r, first_meas_r;
  logic signed [VB-1:0] last_sum_r, last_base_r, last_factor_r, last_meas_r;
  logic [INDEX_BITS-1:0] first_index_r, first_delta_r, last_index_r, last_delta_r;

  logic take_last_r, take_first_r;
  logic [RB-1:0] rs_r, ro_r;
  logic          op_neg_r;

  logic              mode_ratio, val_min, rat_min;
  logic signed [VB:0] sum_ext;
  logic signed [VB-1:0] sum_sat;
  logic              v_take_last, v_take_first;
  logic              r_take_last, r_take_first;

  logic signed [VB-1:0] op_meas, op_cur;
  logic signed [VB:0]   op_diff;
  logic [VB:0]          op_abs;
  logic                 tol_hit, cur_zero;
  logic [RB-1:0]        spec_ratio;
  logic [VB-1:0]        n_mag, d_mag;

  logic          div_busy, div_done;
  logic [DW-1:0] div_quot;
  logic [QX-1:0] q_ext;
  logic [RB-1:0] div_mag, div_ratio;

  assign mode_ratio = (mode_r == flet_pkg::MODE_RAT_MIN) ||
                      (mode_r == flet_pkg::MODE_RAT_MAX);
  assign val_min    = mode_r == flet_pkg::MODE_VAL_MIN;
  assign rat_min    = mode_r == flet_pkg::MODE_RAT_MIN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= flet_pkg::MODE_VAL_MIN;
      tol_r  <= flet_pkg::TOL_BITS'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        flet_pkg::CFG_TRACK_MODE: mode_r <= cfg_data[flet_pkg::MODE_BITS-1:0];
        flet_pkg::CFG_RATIO_TOL:  tol_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturating sum of value and baseline.
  assign sum_ext = {s_value_r[VB-1], s_value_r} + {s_base_r[VB-1], s_base_r};
  always_comb begin
    if (sum_ext[VB] != sum_ext[VB-1]) begin
      sum_sat = sum_ext[VB] ? VMIN : VMAX;
    end else begin
      sum_sat = sum_ext[VB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_value_r  <= in_value;
      s_base_r   <= in_base;
      s_index_r  <= in_index;
      s_delta_r  <= in_delta;
      s_factor_r <= in_factor;
      s_meas_r   <= in_meas;
    end
    if (cmd.calc_sum) begin
      s_sum_r <= sum_sat;
    end
  end

  // Value mode comparisons.
  always_comb begin
    if (val_min) begin
      v_take_last  = (last_index_r == '0) || ((s_base_r != '0) && (s_sum_r <= 0)) ||
                     (s_sum_r <= last_sum_r);
      v_take_first = (first_index_r == '0) || (s_sum_r < first_sum_r);
    end else begin
      v_take_last  = (last_index_r == '0) || (s_sum_r >= last_sum_r);
      v_take_first = (first_index_r == '0) || (s_sum_r > first_sum_r);
    end
  end

  // Ratio mode comparisons of the sample ratio against the other one.
  assign r_take_last  = rat_min ? ($signed(rs_r) <= $signed(ro_r))
                                : ($signed(rs_r) >= $signed(ro_r));
  assign r_take_first = rat_min ? ($signed(rs_r) < $signed(ro_r))
                                : ($signed(rs_r) > $signed(ro_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      take_last_r  <= 1'b0;
      take_first_r <= 1'b0;
    end else begin
      case (cmd.eval)
        flet_pkg::EV_VALUE: begin
          take_last_r  <= v_take_last;
          take_first_r <= v_take_first;
        end
        flet_pkg::EV_FILL: begin
          take_last_r  <= 1'b1;
          take_first_r <= 1'b1;
        end
        flet_pkg::EV_RLAST: begin
          take_last_r  <= r_take_last;
          take_first_r <= 1'b0;
        end
        flet_pkg::EV_RFIRST: begin
          take_first_r <= r_take_first;
        end
        default: ;
      endcase
    end
  end

  // Ratio operand selection and the cases that need no division.
  always_comb begin
    case (cmd.rsel)
      flet_pkg::RSEL_LAST: begin
        op_meas = last_meas_r;
        op_cur  = last_sum_r;
      end
      flet_pkg::RSEL_FIRST: begin
        op_meas = first_meas_r;
        op_cur  = first_sum_r;
      end
      default: begin
        op_meas = s_meas_r;
        op_cur  = s_sum_r;
      end
    endcase
  end

  assign op_diff  = {op_meas[VB-1], op_meas} - {op_cur[VB-1], op_cur};
  assign op_abs   = op_diff[VB] ? (VB+1)'(-op_diff) : op_diff;
  assign tol_hit  = op_abs <= (VB+1)'(tol_r);
  assign cur_zero = op_cur == '0;
  assign n_mag    = op_meas[VB-1] ? VB'(-op_meas) : op_meas;
  assign d_mag    = op_cur[VB-1] ? VB'(-op_cur) : op_cur;

  always_comb begin
    if (tol_hit) begin
      spec_ratio = flet_pkg::RATIO_ONE;
    end else if (op_meas[VB-1]) begin
      spec_ratio = RB'(-flet_pkg::RATIO_SAT);
    end else begin
      spec_ratio = flet_pkg::RATIO_SAT;
    end
  end

  flet_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .numer (n_mag),
    .denom (d_mag),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign q_ext     = QX'(div_quot);
  assign div_mag   = (|q_ext[QX-1:RB-1]) ? flet_pkg::RATIO_SAT : q_ext[RB-1:0];
  assign div_ratio = op_neg_r ? RB'(-div_mag) : div_mag;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      op_neg_r <= op_meas[VB-1] ^ op_cur[VB-1];
    end
    if (cmd.rstore || cmd.div_store) begin
      if (cmd.rsel == flet_pkg::RSEL_SAMPLE) begin
        rs_r <= cmd.rstore ? spec_ratio : div_ratio;
      end else begin
        ro_r <= cmd.rstore ? spec_ratio : div_ratio;
      end
    end
  end

  // Record update. Value modes keep each record's own measured value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sum_r    <= '0;
      first_base_r   <= '0;
      first_index_r  <= '0;
      first_delta_r  <= '0;
      first_factor_r <= '0;
      first_meas_r   <= '0;
      last_sum_r     <= '0;
      last_base_r    <= '0;
      last_index_r   <= '0;
      last_delta_r   <= '0;
      last_factor_r  <= '0;
      last_meas_r    <= '0;
    end else if (cmd.commit && take_last_r) begin
      last_sum_r    <= s_sum_r;
      last_base_r   <= s_base_r;
      last_index_r  <= s_index_r;
      last_delta_r  <= s_delta_r;
      last_factor_r <= s_factor_r;
      if (mode_ratio) begin
        last_meas_r <= s_meas_r;
      end
      if (take_first_r) begin
        first_sum_r    <= s_sum_r;
        first_base_r   <= s_base_r;
        first_index_r  <= s_index_r;
        first_delta_r  <= s_delta_r;
        first_factor_r <= s_factor_r;
        if (mode_ratio) begin
          first_meas_r <= s_meas_r;
        end
      end
    end
  end

  assign rec_bus = {last_meas_r, last_factor_r, last_delta_r, last_index_r,
                    last_base_r, last_sum_r,
                    first_meas_r, first_factor_r, first_delta_r, first_index_r,
                    first_base_r, first_sum_r};

  always_comb begin
    sts            = '0;
    sts.mode_ratio = mode_ratio;
    sts.last_empty = last_index_r == '0;
    sts.take_last  = take_last_r;
    sts.special    = tol_hit || cur_zero;
    sts.div_busy   = div_busy;
    sts.div_done   = div_done;
  end

endmodule

`default_nettype wire

// ===== src/flet_ctrl.sv =====
// ============================================================================
// flet_ctrl
// Sequencer of the tracker: accepts a sample, steps the datapath through the
// sum, the comparisons and up to three ratio divisions, and owns the result
// handshake.
// ============================================================================
`default_nettype none

module flet_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire flet_pkg::status_t  sts,
  output flet_pkg::cmd_t          cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SUM    = 3'd1;
  localparam logic [2:0] ST_VCMP   = 3'd2;
  localparam logic [2:0] ST_RSTART = 3'd3;
  localparam logic [2:0] ST_RWAIT  = 3'd4;
  localparam logic [2:0] ST_RCMP   = 3'd5;
  localparam logic [2:0] ST_RCHK   = 3'd6;
  localparam logic [2:0] ST_COMMIT = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] ridx_r, ridx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       ratio_done;

  always_comb begin
    state_nxt     = state_r;
    ridx_nxt      = ridx_r;
    cmd           = '0;
    cmd.eval      = flet_pkg::EV_NONE;
    cmd.rsel      = ridx_r;
    ratio_done    = 1'b0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.calc_sum = 1'b1;
        if (!sts.mode_ratio) begin
          state_nxt = ST_VCMP;
        end else if (sts.last_empty) begin
          cmd.eval  = flet_pkg::EV_FILL;
          state_nxt = ST_COMMIT;
        end else begin
          ridx_nxt  = flet_pkg::RSEL_SAMPLE;
          state_nxt = ST_RSTART;
        end
      end
      ST_VCMP: begin
        cmd.eval  = flet_pkg::EV_VALUE;
        state_nxt = ST_COMMIT;
      end
      ST_RSTART: begin
        if (sts.special) begin
          cmd.rstore = 1'b1;
          ratio_done = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_RWAIT;
        end
      end
      ST_RWAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          ratio_done    = 1'b1;
        end
      end
      ST_RCMP: begin
        if (ridx_r == flet_pkg::RSEL_LAST) begin
          cmd.eval  = flet_pkg::EV_RLAST;
          state_nxt = ST_RCHK;
        end else begin
          cmd.eval  = flet_pkg::EV_RFIRST;
          state_nxt = ST_COMMIT;
        end
      end
      ST_RCHK: begin
        if (sts.take_last) begin
          ridx_nxt  = flet_pkg::RSEL_FIRST;
          state_nxt = ST_RSTART;
        end else begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (ratio_done) begin
      if (ridx_r == flet_pkg::RSEL_SAMPLE) begin
        ridx_nxt  = flet_pkg::RSEL_LAST;
        state_nxt = ST_RSTART;
      end else begin
        state_nxt = ST_RCMP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ridx_r      <= flet_pkg::RSEL_SAMPLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ridx_r      <= ridx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_wait_has_divider: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RWAIT) |-> (sts.div_busy || sts.div_done))
    else $error("Waiting on the divider while it is neither busy nor done.");

  a_first_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval == flet_pkg::EV_RFIRST) |-> sts.take_last)
    else $error("First record ratio compared although the last record was not taken.");

  a_idle_divider_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !sts.div_busy)
    else $error("Divider still running while the sequencer is idle.");

endmodule

`default_nettype wire

// ===== src/first_last_extremum_tracker_unit.sv =====
// ============================================================================
// first_last_extremum_tracker_unit
// Tracks a first and a last extremum record over a stream of samples, by
// value or by the ratio measured/current, and returns both records after
// every sample.
// ============================================================================
//
//  Channel  Direction  Handshake              Content
//  in_      slave      in_tvalid/in_tready    one sample per request
//  out_     master     out_tvalid/out_tready  both records, one per sample
//  cfg_     write      cfg_wr_en              track_mode, ratio_tolerance
//
// A value mode request passes from acceptance through the sum, the value
// comparison and the commit states, where its result is registered.
// A ratio mode request runs up to three divisions on the bit-serial divider,
// one quotient bit per cycle; ratios within tolerance or with a zero current
// skip the division, as does the fill of empty records.
// A new sample is accepted while the previous result waits; the records are
// updated only once that result has been taken.
// Reset clears both records to empty, track_mode to 0 and ratio_tolerance to 1.
//
`default_nettype none

module first_last_extremum_tracker_unit #(
  parameter int VALUE_BITS = flet_pkg::VALUE_BITS_DEF,
  parameter int INDEX_BITS = flet_pkg::INDEX_BITS_DEF,
  localparam int IN_BITS   = 4 * VALUE_BITS + 2 * INDEX_BITS,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((2 * IN_BITS + 7) / 8) * 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // sample_value, sample_baseline, sample_index, sample_delta,
  // correction_factor, measured_value
  input  wire logic [IN_W-1:0]                      in_tdata,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // first_value, first_base, first_position, first_width, first_factor,
  // first_numerator, last_value, last_base, last_position, last_width,
  // last_factor, last_numerator
  output logic [OUT_W-1:0]                          out_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [flet_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [flet_pkg::TOL_BITS-1:0]        cfg_data
);

  localparam int VB = VALUE_BITS;
  localparam int IB = INDEX_BITS;

  flet_pkg::cmd_t    cmd;
  flet_pkg::status_t sts;
  logic [2*IN_BITS-1:0] rec_bus;

  flet_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  flet_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_value  (in_tdata[VB-1:0]),
    .in_base   (in_tdata[2*VB-1:VB]),
    .in_index  (in_tdata[2*VB+IB-1:2*VB]),
    .in_delta  (in_tdata[2*VB+2*IB-1:2*VB+IB]),
    .in_factor (in_tdata[3*VB+2*IB-1:2*VB+2*IB]),
    .in_meas   (in_tdata[4*VB+2*IB-1:3*VB+2*IB]),
    .cmd       (cmd),
    .sts       (sts),
    .rec_bus   (rec_bus)
  );

  assign out_tdata = OUT_W'(rec_bus);

endmodule

`default_nettype wire
